@@ src/bphd_pkg.sv @@
package bphd_pkg;

	localparam int NUM_BUTTONS = 4;
	// Level and index fields are sized for four buttons.
	localparam int LANE_CAP = 4;
	localparam int NUM_LANES = (NUM_BUTTONS < LANE_CAP) ? NUM_BUTTONS : LANE_CAP;
	localparam int LANE_W = $clog2(LANE_CAP);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] HELD_THRESHOLD_RST = 16'd1000;
	localparam logic [15:0] MIN_PRESS_RST = 16'd50;

	localparam logic KIND_SHORT = 1'b0;
	localparam logic KIND_HELD = 1'b1;

	typedef enum logic [0:0] {
		REG_HELD_THRESHOLD = 1'b0,
		REG_MIN_PRESS      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [3:0]  button_levels;
	} in_item_t;

	typedef struct packed {
		logic [1:0] button_index;
		logic       event_kind;
		logic       last_event;
	} out_item_t;

	typedef struct packed {
		logic [15:0] held_threshold_ms;
		logic [15:0] min_press_ms;
	} cfg_t;

	// One poll's worth of events: a hit mask and the kind for each lane.
	typedef struct packed {
		logic [LANE_CAP-1:0] hit;
		logic [LANE_CAP-1:0] kind;
	} poll_rec_t;

	typedef struct packed {
		logic busy;
		logic emit;
	} back_stat_t;

endpackage

@@ src/bphd_front.sv @@
module bphd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  bphd_pkg::in_item_t  item,
	input  bphd_pkg::cfg_t      cfg,
	output bphd_pkg::poll_rec_t rec,
	output logic                rec_valid
);

	localparam int NUM_LANES_L = bphd_pkg::NUM_LANES;

	logic [NUM_LANES_L-1:0]        was_down_q;
	logic [NUM_LANES_L-1:0]        held_sent_q;
	logic [31:0]                   press_start_q [NUM_LANES_L];

	logic [NUM_LANES_L-1:0] down;
	logic [NUM_LANES_L-1:0] edge_press;
	logic [NUM_LANES_L-1:0] held_fire;
	logic [31:0]            elapsed [NUM_LANES_L];

	always_comb begin
		rec = '0;
		for (int i = 0; i < NUM_LANES_L; i++) begin
			down[i] = ~item.button_levels[i];
			elapsed[i] = item.time_ms - press_start_q[i];
			edge_press[i] = down[i] & ~was_down_q[i];
			held_fire[i] = down[i] & was_down_q[i] & ~held_sent_q[i] &
				(elapsed[i] >= 32'(cfg.held_threshold_ms));
			if (held_fire[i]) begin
				rec.hit[i] = 1'b1;
				rec.kind[i] = bphd_pkg::KIND_HELD;
			end else if (~down[i] & was_down_q[i] & ~held_sent_q[i] &
					(elapsed[i] >= 32'(cfg.min_press_ms))) begin
				rec.hit[i] = 1'b1;
				rec.kind[i] = bphd_pkg::KIND_SHORT;
			end
		end
		rec_valid = accept & (|rec.hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_down_q <= '0;
			held_sent_q <= '0;
		end else if (accept) begin
			was_down_q <= down;
			for (int i = 0; i < NUM_LANES_L; i++) begin
				if (edge_press[i]) begin
					held_sent_q[i] <= 1'b0;
				end else if (held_fire[i]) begin
					held_sent_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_LANES_L; i++) begin
				if (edge_press[i]) begin
					press_start_q[i] <= item.time_ms;
				end
			end
		end
	end

endmodule

@@ src/bphd_fifo.sv @@
module bphd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  bphd_pkg::poll_rec_t wr_data,
	output logic                is_full,
	input  logic                rd_en,
	output bphd_pkg::poll_rec_t rd_data,
	output logic                is_empty
);

	bphd_pkg::poll_rec_t                  mem_q [bphd_pkg::FIFO_DEPTH];
	logic [bphd_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
	logic [bphd_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
	logic [bphd_pkg::FIFO_CNT_W-1:0]      count_q;
	logic                                 do_wr;
	logic                                 do_rd;

	assign is_full = (count_q == bphd_pkg::FIFO_CNT_W'(bphd_pkg::FIFO_DEPTH));
	assign is_empty = (count_q == '0);
	assign do_wr = wr_en & ~is_full;
	assign do_rd = rd_en & ~is_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/bphd_back.sv @@
module bphd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bphd_pkg::poll_rec_t  rec,
	input  logic                 rec_empty,
	output logic                 rec_take,
	output bphd_pkg::out_item_t  out_item,
	output logic                 out_valid,
	input  logic                 out_take,
	output bphd_pkg::back_stat_t stat
);

	logic [bphd_pkg::LANE_CAP-1:0] work_hit_q;
	logic [bphd_pkg::LANE_CAP-1:0] work_kind_q;
	bphd_pkg::out_item_t           out_q;
	logic                          out_valid_q;

	logic                          slot_free;
	logic                          have;
	logic                          emit;
	logic [bphd_pkg::LANE_W-1:0]   idx;
	logic [bphd_pkg::LANE_CAP-1:0] next_hit;

	always_comb begin
		idx = '0;
		for (int i = bphd_pkg::LANE_CAP - 1; i >= 0; i--) begin
			if (work_hit_q[i]) begin
				idx = bphd_pkg::LANE_W'(i);
			end
		end
		have = |work_hit_q;
		slot_free = ~out_valid_q | out_take;
		emit = slot_free & have;
		next_hit = work_hit_q;
		next_hit[idx] = 1'b0;
		// Refill as the last event of the current poll leaves, so no bubble.
		rec_take = ~rec_empty & (~have | (emit & ~(|next_hit)));
	end

	assign out_item = out_q;
	assign out_valid = out_valid_q;
	assign stat.busy = have;
	assign stat.emit = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_hit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_take) begin
				work_hit_q <= rec.hit;
			end else if (emit) begin
				work_hit_q <= next_hit;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			work_kind_q <= rec.kind;
		end
		if (emit) begin
			out_q.button_index <= 2'(idx);
			out_q.event_kind <= work_kind_q[idx];
			out_q.last_event <= ~(|next_hit);
		end
	end

endmodule

@@ src/button_press_hold_detector.sv @@
// Channel   Handshake                 Payload
// ------    ---------------------     --------------------------------------
// poll in   push / full               in_item  (time_ms, button_levels)
// event out empty / pop               out_item (button_index, event_kind,
//                                               last_event)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data (16 bit)
//
// A poll is taken every cycle while full is low; the front updates button
// state in that same cycle and queues the poll's events (up to four polls).
// The back hands out one event per cycle while the output slot is empty or
// popped; a poll yields four events at most. Polls with no events are not
// queued. The first event passes the queue, work and output registers.
// Reset clears button state, the queue and the output slot; config returns
// to 1000 ms held threshold and 50 ms minimum press. cfg_ready is always high.
module button_press_hold_detector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bphd_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output bphd_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	bphd_pkg::cfg_t       cfg_q;
	bphd_pkg::poll_rec_t  front_rec;
	logic                 front_rec_valid;
	bphd_pkg::poll_rec_t  fifo_rec;
	logic                 fifo_full;
	logic                 fifo_empty;
	logic                 fifo_take;
	logic                 out_valid;
	bphd_pkg::back_stat_t back_stat;
	logic                 in_accept;

	// Config writes are registered into cfg_q; the block never stalls them.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.held_threshold_ms <= bphd_pkg::HELD_THRESHOLD_RST;
			cfg_q.min_press_ms <= bphd_pkg::MIN_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bphd_pkg::cfg_reg_t'(cfg_index))
				bphd_pkg::REG_HELD_THRESHOLD: cfg_q.held_threshold_ms <= cfg_data;
				bphd_pkg::REG_MIN_PRESS:      cfg_q.min_press_ms <= cfg_data;
			endcase
		end
	end

	// Hold new polls only when the event queue has no room left.
	assign full = fifo_full;
	assign in_accept = push & ~full;

	bphd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.item      (in_item),
		.cfg       (cfg_q),
		.rec       (front_rec),
		.rec_valid (front_rec_valid)
	);

	// Only polls that produce at least one event enter the queue.
	bphd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_rec_valid),
		.wr_data  (front_rec),
		.is_full  (fifo_full),
		.rd_en    (fifo_take),
		.rd_data  (fifo_rec),
		.is_empty (fifo_empty)
	);

	// Serialize each queued poll into events, lowest button first.
	bphd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (fifo_rec),
		.rec_empty (fifo_empty),
		.rec_take  (fifo_take),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_take  (pop),
		.stat      (back_stat)
	);

	assign empty = ~out_valid;

	// An event without the last marker must have siblings still pending.
	a_more_after_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_item.last_event) |-> back_stat.busy)
		else $error("event without last marker but nothing pending");

	// Every emitted event must appear on the output next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emit |=> !empty)
		else $error("emitted event not presented");

	// A config write to the held threshold must be visible next cycle.
	a_cfg_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == bphd_pkg::REG_HELD_THRESHOLD) |=>
		(cfg_q.held_threshold_ms == $past(cfg_data)))
		else $error("held threshold write lost");

endmodule
